// ===== hdl/base64_stream_encoder_defines.svh =====
// Assertion macros shared by the base64 stream encoder checker.
// Depends on nothing; included by files that assert.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define B64SE_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define B64SE_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/b64se_pkg.sv =====
// Types, constants and the symbol table of the base64 stream encoder.
// No dependencies.
package b64se_pkg;

   localparam int unsigned JOB_CHARS = 5;

   localparam logic [4:0] GROUPS_PER_LINE = 5'd19;
   localparam logic [7:0] PAD_CHAR        = 8'h3D;
   localparam logic [7:0] NEWLINE_CHAR    = 8'h0A;

   // bytes held in the current group
   localparam logic [1:0] PHASE_NONE = 2'd0;
   localparam logic [1:0] PHASE_ONE  = 2'd1;
   localparam logic [1:0] PHASE_TWO  = 2'd2;

   localparam logic [2:0] COUNT_FOUR = 3'd4;
   localparam logic [2:0] COUNT_FIVE = 3'd5;

   // one entry of the job queue: up to five characters, chars[0] goes first
   typedef struct packed {
      logic [JOB_CHARS-1:0][7:0] chars;
      logic [2:0]                count;
      logic                      last;
   } job_type;

   // 6-bit value to base64 alphabet character
   function automatic logic [7:0] sym6(input logic [5:0] v);
      logic [7:0] w;
      begin
         w = {2'b00, v};
         if (w < 8'd26) begin
            return 8'd65 + w;
         end else if (w < 8'd52) begin
            return 8'd71 + w;
         end else if (w < 8'd62) begin
            return w - 8'd4;
         end else if (w == 8'd62) begin
            return 8'h2B;
         end else begin
            return 8'h2F;
         end
      end
   endfunction

endpackage

// ===== hdl/b64se_front.sv =====
// Front end: groups incoming bytes, tracks line position, builds character jobs.
// Depends on b64se_pkg.
module b64se_front
   import b64se_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic       wrap_enable,
   output logic       push,
   output job_type    job
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  groups_ff, groups_in;
   logic [7:0]  b0, b1;
   logic [4:0]  groups_inc;
   logic        line_full;
   logic        emit;

   always_comb begin
      b0         = held_ff[15:8];
      b1         = held_ff[7:0];
      groups_inc = groups_ff + 5'd1;
      line_full  = groups_inc >= GROUPS_PER_LINE;
      held_in    = held_ff;
      phase_in   = phase_ff;
      groups_in  = groups_ff;
      job.chars  = '0;
      job.count  = wrap_enable ? COUNT_FIVE : COUNT_FOUR;
      job.last   = last_byte;
      emit       = last_byte;
      unique case (phase_ff)
         PHASE_NONE: begin
            held_in      = {data_byte, 8'h00};
            phase_in     = PHASE_ONE;
            job.chars[0] = sym6(data_byte[7:2]);
            job.chars[1] = sym6({data_byte[1:0], 4'h0});
            job.chars[2] = PAD_CHAR;
            job.chars[3] = PAD_CHAR;
            job.chars[4] = NEWLINE_CHAR;
         end
         PHASE_ONE: begin
            held_in      = {b0, data_byte};
            phase_in     = PHASE_TWO;
            job.chars[0] = sym6(b0[7:2]);
            job.chars[1] = sym6({b0[1:0], data_byte[7:4]});
            job.chars[2] = sym6({data_byte[3:0], 2'b00});
            job.chars[3] = PAD_CHAR;
            job.chars[4] = NEWLINE_CHAR;
         end
         default: begin
            held_in      = '0;
            phase_in     = PHASE_NONE;
            groups_in    = line_full ? 5'd0 : groups_inc;
            emit         = 1'b1;
            job.chars[0] = sym6(b0[7:2]);
            job.chars[1] = sym6({b0[1:0], b1[7:4]});
            job.chars[2] = sym6({b1[3:0], data_byte[7:6]});
            job.chars[3] = sym6(data_byte[5:0]);
            job.chars[4] = NEWLINE_CHAR;
            job.count    = (wrap_enable && (line_full || last_byte)) ? COUNT_FIVE
                                                                     : COUNT_FOUR;
         end
      endcase
      // end of message: back to a fresh start
      if (last_byte) begin
         held_in   = '0;
         phase_in  = PHASE_NONE;
         groups_in = '0;
      end
      push = accept && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         phase_ff  <= PHASE_NONE;
         groups_ff <= '0;
      end else if (accept) begin
         held_ff   <= held_in;
         phase_ff  <= phase_in;
         groups_ff <= groups_in;
      end
   end

endmodule

// ===== hdl/b64se_queue.sv =====
// Short FIFO of character jobs between front and back ends.
// Depends on b64se_pkg.
module b64se_queue
   import b64se_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == DEPTH_CNT);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/b64se_back.sv =====
// Back end: walks the head job into the output register, one character per cycle unless stalled.
// Depends on b64se_pkg.
module b64se_back
   import b64se_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load, at_end;

   assign at_end = (idx_ff == head_job.count - 3'd1);
   assign load   = head_valid && (!valid_ff || !rsp_stall);
   assign pop    = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = at_end ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= head_job.chars[idx_ff];
         last_ff <= head_job.last && at_end;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;

endmodule

// ===== hdl/base64_stream_encoder.sv =====
// Streaming base64 encoder (standard alphabet, '=' padding) with optional line
// wrap. Raw bytes come in one word per req_ handshake, the final byte of a
// message flagged by req_last_byte; encoded characters leave one word per rsp_
// handshake, rsp_out_last flagging the final character. Every three bytes give
// four symbols; a partial last group is padded with '='. With wrap_enable set,
// a newline follows every 57 bytes and the message closes with a newline unless
// its last line is already closed. An input byte is taken in every cycle while
// the job queue has room; a job enters the queue at the edge that takes its
// byte, and the back end moves its characters from the queue head into the
// output register. The output register drains one character per cycle while
// rsp_stall is low, so the sustained rate is set by the output port, not the input.
// wrap_enable is written through csr_ (always ready) and must only change
// while the block is idle. Depends on b64se_pkg and the front, queue and back
// modules.
module base64_stream_encoder
   import b64se_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // byte input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   // character output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   // control register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_wrap_enable
);

   logic    wrap_enable_ff;
   logic    accept;
   logic    push, pop;
   logic    q_empty, q_full;
   job_type push_job, head_job;

   // single control register, write always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         wrap_enable_ff <= csr_wrap_enable;
      end
   end

   // front stalls only on a full queue
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   b64se_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .wrap_enable (wrap_enable_ff),
      .push        (push),
      .job         (push_job)
   );

   b64se_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   b64se_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .head_valid   (!q_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

// ===== hdl/b64se_checker.sv =====
// Port-level checker for the base64 stream encoder, bound to the top level.
// Depends on base64_stream_encoder_defines.svh.
`include "base64_stream_encoder_defines.svh"

module b64se_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_out_last,
   input logic       csr_valid,
   input logic       csr_ready
);

   logic legal_char;

   assign legal_char = (rsp_out_char >= 8'h41 && rsp_out_char <= 8'h5A)
                    || (rsp_out_char >= 8'h61 && rsp_out_char <= 8'h7A)
                    || (rsp_out_char >= 8'h30 && rsp_out_char <= 8'h39)
                    || rsp_out_char == 8'h2B || rsp_out_char == 8'h2F
                    || rsp_out_char == 8'h3D || rsp_out_char == 8'h0A;

   `B64SE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_char) && $stable(rsp_out_last), "stalled output word changed")
   `B64SE_ASSERT_NOW(a_legal_char, clock, reset, rsp_valid, legal_char, "output word is not a base64 character")
   `B64SE_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready, "control write not taken")
   `B64SE_ASSERT_NOW(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid, "output valid right after reset")
   `B64SE_ASSERT_NOW(a_req_stall_known, clock, reset, req_valid, !$isunknown(req_stall), "input stall unknown")

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_char (rsp_out_char),
   .rsp_out_last (rsp_out_last),
   .csr_valid    (csr_valid),
   .csr_ready    (csr_ready)
);

// ===== verif/b64se_stream_check.sv =====
`timescale 1ns / 100ps
// Character predictor and scoreboard for base64_stream_encoder.
// Watches the req_, rsp_ and csr_ channels; depends on b64se_pkg.
module b64se_stream_check
   import b64se_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_char,
   input  logic        rsp_out_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_wrap_enable,
   output int unsigned error_count,
   output int unsigned chars_pending
);

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } enc_char_type;

   enc_char_type expected_chars[$];
   int unsigned  fails;

   // encoder state as seen from outside
   logic        wrap_on;
   logic [15:0] held_pair;
   logic [1:0]  phase;
   logic [4:0]  line_groups;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      int idx;
      idx = 63 - int'(v);
      return ALPHABET[8*idx +: 8];
   endfunction

   // Advance the state by one byte and queue the characters it releases.
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] out [5];
      int         n;
      logic       line_full;
      b0 = held_pair[15:8];
      b1 = held_pair[7:0];
      n  = 0;
      unique case (phase)
         PHASE_NONE: begin
            held_pair = {b, 8'h00};
            phase     = PHASE_ONE;
            if (fin) begin
               out[0] = b64_char(b[7:2]);
               out[1] = b64_char({b[1:0], 4'b0000});
               out[2] = PAD_CHAR;
               out[3] = PAD_CHAR;
               n      = 4;
            end
         end
         PHASE_ONE: begin
            held_pair = {b0, b};
            phase     = PHASE_TWO;
            if (fin) begin
               out[0] = b64_char(b0[7:2]);
               out[1] = b64_char({b0[1:0], b[7:4]});
               out[2] = b64_char({b[3:0], 2'b00});
               out[3] = PAD_CHAR;
               n      = 4;
            end
         end
         default: begin
            out[0]      = b64_char(b0[7:2]);
            out[1]      = b64_char({b0[1:0], b1[7:4]});
            out[2]      = b64_char({b1[3:0], b[7:6]});
            out[3]      = b64_char(b[5:0]);
            n           = 4;
            phase       = PHASE_NONE;
            held_pair   = 16'h0000;
            line_groups = line_groups + 5'd1;
            line_full   = (line_groups >= GROUPS_PER_LINE);
            if (line_full) line_groups = 5'd0;
            // a group closing on the line end gets one newline, not two
            if (wrap_on && (line_full || fin)) begin
               out[4] = NEWLINE_CHAR;
               n      = 5;
            end
         end
      endcase
      // partial groups close their line only on the last byte
      if (fin && n == 4 && phase != PHASE_NONE && wrap_on) begin
         out[4] = NEWLINE_CHAR;
         n      = 5;
      end
      if (fin) begin
         held_pair   = 16'h0000;
         phase       = PHASE_NONE;
         line_groups = 5'd0;
      end
      for (int i = 0; i < n; i++) expected_chars.push_back('{out[i], fin && (i == n - 1)});
   endfunction

   always @(posedge clock) begin : track
      enc_char_type want;
      if (reset) begin
         expected_chars.delete();
         fails       = 0;
         wrap_on     = 1'b0;
         held_pair   = 16'h0000;
         phase       = PHASE_NONE;
         line_groups = 5'd0;
      end else begin
         if (csr_valid && csr_ready) wrap_on = csr_wrap_enable;
         if (req_valid && !req_stall) encode_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("out_char: expected nothing, got %h (out_last %b)",
                      rsp_out_char, rsp_out_last);
               fails++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.ch) begin
                  $error("out_char: expected %h, got %h", want.ch, rsp_out_char);
                  fails++;
               end
               if (rsp_out_last !== want.fin) begin
                  $error("out_last: expected %b, got %b", want.fin, rsp_out_last);
                  fails++;
               end
            end
         end
      end
      error_count   <= fails;
      chars_pending <= unsigned'(expected_chars.size());
   end

endmodule

// ===== verif/tb_base64_stream_encoder.sv =====
`timescale 1ns / 100ps
// Top of the base64_stream_encoder testbench: clock, reset, byte and stall
// stimulus, wrap settings and verdict. Depends on b64se_pkg and b64se_stream_check.
module tb_base64_stream_encoder;
   import b64se_pkg::*;

   localparam int unsigned MSG_BYTES      = 470;  // random part stops past this
   localparam int unsigned SETTLE_CYCLES  = 8;    // extra wait after the last predicted character
   localparam int unsigned TAIL_CYCLES    = 20;
   localparam int unsigned WATCHDOG_LIMIT = 2000; // quiet cycles before giving up

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte   = 8'h00;
   logic        req_last_byte   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_out_last;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic        csr_wrap_enable = 1'b0;

   int unsigned error_count;
   int unsigned chars_pending;
   int unsigned bytes_sent;
   int unsigned quiet_cycles;
   logic        wrap_now;      // setting last written
   int unsigned stall_hold;    // cycles left in the current back-pressure segment

   base64_stream_encoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_out_last    (rsp_out_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wrap_enable (csr_wrap_enable)
   );

   b64se_stream_check i_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_out_last    (rsp_out_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wrap_enable (csr_wrap_enable),
      .error_count     (error_count),
      .chars_pending   (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver back-pressure in segments: short free runs, short stalls,
   // long free stretches and the occasional long stall.
   always @(posedge clock) begin
      int unsigned r;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 19);
         end else if (r < 85) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 2);
         end else if (r < 95) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 59);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(9, 39);
         end
      end
   end

   // Any accepted word on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sender gap before a byte; burst messages send back to back.
   function automatic int unsigned pick_gap(input bit burst);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst || r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one byte and hold it until accepted. Valid stays high into the
   // next byte when there is no gap, so it is never dropped and raised in
   // the same step.
   task automatic push_byte(input logic [7:0] b, input logic last, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Wait until every predicted character has come out, then wait out the
   // settle time, since a held byte may still sit inside the block.
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (chars_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_wrap(input logic v);
      quiesce();
      csr_valid       <= 1'b1;
      csr_wrap_enable <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      wrap_now   = v;
   endtask

   // One message of random bytes; the wrap setting may flip partway.
   task automatic send_message(input int unsigned len, input int unsigned flip_at,
                               input bit burst);
      for (int unsigned i = 0; i < len; i++) begin
         if (flip_at != 0 && i == flip_at) set_wrap(!wrap_now);
         push_byte(8'($urandom_range(0, 255)), i == len - 1, pick_gap(burst));
      end
   endtask

   initial begin
      int unsigned len;
      int unsigned flip_at;
      int unsigned r;
      bytes_sent = 0;
      wrap_now   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: wrap off, as after reset ----
      push_byte(8'h00, 1'b1, 0);                  // single byte, all zero
      push_byte(8'hFF, 1'b1, 0);                  // single byte, all ones
      push_byte(8'hFC, 1'b0, 0);                  // two-byte message
      push_byte(8'h03, 1'b1, 1);
      push_byte(8'h00, 1'b0, 0);                  // exactly one group, no newline
      push_byte(8'hFF, 1'b0, 0);
      push_byte(8'h80, 1'b1, 0);

      // ---- directed: wrap on, closing newline on each form of last group ----
      set_wrap(1'b1);
      push_byte(8'hA5, 1'b1, 0);
      push_byte(8'h5A, 1'b0, 2);
      push_byte(8'hC3, 1'b1, 0);
      push_byte(8'h12, 1'b0, 0);
      push_byte(8'h34, 1'b0, 0);
      push_byte(8'h56, 1'b1, 0);                  // five characters from one byte
      push_byte(8'h7E, 1'b0, 0);                  // a group then a lone byte
      push_byte(8'h81, 1'b0, 0);
      push_byte(8'h3C, 1'b0, 0);
      push_byte(8'hC0, 1'b1, 0);

      // wrap turned off with two bytes held; the rest uses the new setting
      push_byte(8'h01, 1'b0, 0);
      push_byte(8'h02, 1'b0, 0);
      set_wrap(1'b0);
      push_byte(8'h03, 1'b0, 0);
      push_byte(8'h04, 1'b1, 0);

      // ---- random messages ----
      // Lengths lean on the line size: exact multiples of 57 make the last
      // group land on a line end, 56 and 58 fall one byte either side.
      while (bytes_sent < MSG_BYTES) begin
         if ($urandom_range(0, 9) < 3) set_wrap(1'($urandom_range(0, 1)));
         r = $urandom_range(0, 99);
         if (r < 8)       len = 57;
         else if (r < 12) len = 114;
         else if (r < 18) len = $urandom_range(0, 1) ? 56 : 58;
         else if (r < 30) len = 3 * $urandom_range(1, 10);
         else             len = $urandom_range(1, 12);
         // long messages sometimes change the wrap setting midway; the line
         // count carries on across the change
         flip_at = (len >= 40 && $urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : 0;
         send_message(len, flip_at, $urandom_range(0, 3) == 0);
      end

      // ---- drain and verdict ----
      req_valid <= 1'b0;
      do @(posedge clock); while (chars_pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
